/* hw/rtl/jbt_pkg.sv */
// ----------------------------------------------------------------------------
// jbt_pkg
// shared types, token and error codes and keyword tables of the json tokenizer
// ----------------------------------------------------------------------------
package jbt_pkg;

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_STRING  = 7'b0000010,
      MODE_ESCAPE  = 7'b0000100,
      MODE_HEX     = 7'b0001000,
      MODE_NUMBER  = 7'b0010000,
      MODE_KEYWORD = 7'b0100000,
      MODE_DONE    = 7'b1000000
   } lex_mode_type;

   localparam logic [4:0] TK_OBJ_BEGIN = 5'd0;
   localparam logic [4:0] TK_OBJ_END   = 5'd1;
   localparam logic [4:0] TK_ARR_BEGIN = 5'd2;
   localparam logic [4:0] TK_ARR_END   = 5'd3;
   localparam logic [4:0] TK_COMMA     = 5'd4;
   localparam logic [4:0] TK_COLON     = 5'd5;
   localparam logic [4:0] TK_STR_BEGIN = 5'd6;
   localparam logic [4:0] TK_STR_CHAR  = 5'd7;
   localparam logic [4:0] TK_STR_END   = 5'd8;
   localparam logic [4:0] TK_NUM_CHAR  = 5'd9;
   localparam logic [4:0] TK_NUM_INT   = 5'd10;
   localparam logic [4:0] TK_NUM_DBL   = 5'd11;
   localparam logic [4:0] TK_TRUE      = 5'd12;
   localparam logic [4:0] TK_EOF       = 5'd15;
   localparam logic [4:0] TK_ERROR     = 5'd16;

   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_UNKNOWN_BYTE = 4'd1;
   localparam logic [3:0] ERR_BSLASH_EOF   = 4'd2;
   localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd3;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
   localparam logic [3:0] ERR_EOF_IN_HEX   = 4'd5;
   localparam logic [3:0] ERR_HEX_RANGE    = 4'd6;
   localparam logic [3:0] ERR_NON_ASCII    = 4'd7;
   localparam logic [3:0] ERR_BAD_KEYWORD  = 4'd8;
   localparam logic [3:0] ERR_EOF_IN_KW    = 4'd9;
   localparam logic [3:0] ERR_OPEN_STRING  = 4'd10;

   localparam logic [2:0] HEX_DIGITS = 3'd4;
   localparam logic [7:0] ASCII_MAX  = 8'd127;

   typedef struct packed {
      logic [4:0] token_kind;
      logic [6:0] char_value;
      logic [3:0] error_code;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      lex_mode_type mode;
      logic [2:0]   hex_count;
      logic [15:0]  hex_accum;
      logic [1:0]   keyword_id;
      logic [2:0]   keyword_pos;
      logic         number_is_double;
      logic         halted;
      logic [3:0]   err_code;
   } lex_state_type;

   typedef struct packed {
      logic          emit;
      result_type    res;
      lex_state_type st;
   } idle_step_type;

   function automatic result_type make_result(logic [4:0] kind, logic [6:0] ch,
                                              logic [3:0] err);
      result_type r;
      r.token_kind  = kind;
      r.char_value  = ch;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic logic [2:0] kw_len(logic [1:0] id);
      logic [2:0] len;
      case (id)
         2'd0:    len = 3'd4;
         2'd1:    len = 3'd5;
         2'd2:    len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] kw_char(logic [1:0] id, logic [2:0] pos);
      logic [7:0] c;
      case ({id, pos})
         {2'd0, 3'd0}: c = "t";
         {2'd0, 3'd1}: c = "r";
         {2'd0, 3'd2}: c = "u";
         {2'd0, 3'd3}: c = "e";
         {2'd1, 3'd0}: c = "f";
         {2'd1, 3'd1}: c = "a";
         {2'd1, 3'd2}: c = "l";
         {2'd1, 3'd3}: c = "s";
         {2'd1, 3'd4}: c = "e";
         {2'd2, 3'd0}: c = "n";
         {2'd2, 3'd1}: c = "u";
         {2'd2, 3'd2}: c = "l";
         {2'd2, 3'd3}: c = "l";
         default:      c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/jbt_lexer.sv */
// ----------------------------------------------------------------------------
// jbt_lexer
// next-state and result logic of the tokenizer for one input transaction
// ----------------------------------------------------------------------------
module jbt_lexer import jbt_pkg::*; (
   input  lex_state_type cur_state,
   input  logic [7:0]    in_byte,
   input  logic          end_of_input,
   output lex_state_type nxt_state,
   output logic [1:0]    result_count,
   output result_type    result0,
   output result_type    result1
);

   function automatic idle_step_type idle_step(logic [7:0] b, lex_state_type s);
      idle_step_type o;
      o.emit    = 1'b1;
      o.st      = s;
      o.st.mode = MODE_IDLE;
      o.res     = make_result(TK_ERROR, 7'd0, ERR_NONE);
      case (b)
         "{": o.res = make_result(TK_OBJ_BEGIN, 7'd0, ERR_NONE);
         "}": o.res = make_result(TK_OBJ_END, 7'd0, ERR_NONE);
         "[": o.res = make_result(TK_ARR_BEGIN, 7'd0, ERR_NONE);
         "]": o.res = make_result(TK_ARR_END, 7'd0, ERR_NONE);
         ",": o.res = make_result(TK_COMMA, 7'd0, ERR_NONE);
         ":": o.res = make_result(TK_COLON, 7'd0, ERR_NONE);
         "\"": begin
            o.st.mode = MODE_STRING;
            o.res     = make_result(TK_STR_BEGIN, 7'd0, ERR_NONE);
         end
         "t", "f", "n": begin
            o.emit           = 1'b0;
            o.st.keyword_id  = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
            o.st.keyword_pos = 3'd1;
            o.st.mode        = MODE_KEYWORD;
         end
         " ", "\t", "\r", "\n": o.emit = 1'b0;
         default: begin
            if (b == "-" || (b >= "0" && b <= "9")) begin
               o.st.number_is_double = 1'b0;
               o.st.mode             = MODE_NUMBER;
               o.res                 = make_result(TK_NUM_CHAR, b[6:0], ERR_NONE);
            end else begin
               o.st.halted   = 1'b1;
               o.st.err_code = ERR_UNKNOWN_BYTE;
               o.st.mode     = MODE_IDLE;
               o.res         = make_result(TK_ERROR, 7'd0, ERR_UNKNOWN_BYTE);
            end
         end
      endcase
      return o;
   endfunction

   idle_step_type idle_out;
   logic [3:0]    hex_digit;
   logic          hex_ok;
   logic [15:0]   hex_accum_new;
   logic [2:0]    hex_count_new;
   logic [2:0]    kw_pos_new;
   logic [3:0]    fail_code;
   logic          fail;
   logic [4:0]    num_end_kind;

   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      if (in_byte >= "0" && in_byte <= "9") begin
         hex_digit = 4'(in_byte - "0");
      end else if (in_byte >= "a" && in_byte <= "f") begin
         hex_digit = 4'(in_byte - "a" + 8'd10);
      end else if (in_byte >= "A" && in_byte <= "F") begin
         hex_digit = 4'(in_byte - "A" + 8'd10);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign idle_out      = idle_step(in_byte, cur_state);
   assign hex_accum_new = {cur_state.hex_accum[11:0], hex_digit};
   assign hex_count_new = cur_state.hex_count + 3'd1;
   assign kw_pos_new    = cur_state.keyword_pos + 3'd1;
   assign num_end_kind  = cur_state.number_is_double ? TK_NUM_DBL : TK_NUM_INT;

   always_comb begin
      nxt_state    = cur_state;
      result_count = 2'd0;
      result0      = make_result(TK_ERROR, 7'd0, ERR_NONE);
      result1      = make_result(TK_ERROR, 7'd0, ERR_NONE);
      fail         = 1'b0;
      fail_code    = ERR_NONE;
      if (cur_state.halted) begin
         result_count = 2'd1;
         result0      = make_result(TK_ERROR, 7'd0, cur_state.err_code);
      end else if (cur_state.mode == MODE_DONE) begin
         result_count = 2'd1;
         result0      = make_result(TK_EOF, 7'd0, ERR_NONE);
      end else if (end_of_input) begin
         case (cur_state.mode)
            MODE_STRING: begin
               fail      = 1'b1;
               fail_code = ERR_OPEN_STRING;
            end
            MODE_ESCAPE: begin
               fail      = 1'b1;
               fail_code = ERR_BSLASH_EOF;
            end
            MODE_HEX: begin
               fail      = 1'b1;
               fail_code = ERR_EOF_IN_HEX;
            end
            MODE_KEYWORD: begin
               fail      = 1'b1;
               fail_code = ERR_EOF_IN_KW;
            end
            MODE_NUMBER: begin
               nxt_state.mode = MODE_DONE;
               result_count   = 2'd2;
               result0        = make_result(num_end_kind, 7'd0, ERR_NONE);
               result1        = make_result(TK_EOF, 7'd0, ERR_NONE);
            end
            default: begin
               nxt_state.mode = MODE_DONE;
               result_count   = 2'd1;
               result0        = make_result(TK_EOF, 7'd0, ERR_NONE);
            end
         endcase
      end else begin
         case (cur_state.mode)
            MODE_IDLE: begin
               nxt_state    = idle_out.st;
               result_count = {1'b0, idle_out.emit};
               result0      = idle_out.res;
            end
            MODE_STRING: begin
               if (in_byte == "\"") begin
                  nxt_state.mode = MODE_IDLE;
                  result_count   = 2'd1;
                  result0        = make_result(TK_STR_END, 7'd0, ERR_NONE);
               end else if (in_byte == "\\") begin
                  nxt_state.mode = MODE_ESCAPE;
               end else if (in_byte > ASCII_MAX) begin
                  fail      = 1'b1;
                  fail_code = ERR_NON_ASCII;
               end else begin
                  result_count = 2'd1;
                  result0      = make_result(TK_STR_CHAR, in_byte[6:0], ERR_NONE);
               end
            end
            MODE_ESCAPE: begin
               nxt_state.mode = MODE_STRING;
               result_count   = 2'd1;
               case (in_byte)
                  "\"":    result0 = make_result(TK_STR_CHAR, 7'h22, ERR_NONE);
                  "\\":    result0 = make_result(TK_STR_CHAR, 7'h5C, ERR_NONE);
                  "/":     result0 = make_result(TK_STR_CHAR, 7'h2F, ERR_NONE);
                  "b":     result0 = make_result(TK_STR_CHAR, 7'd8, ERR_NONE);
                  "f":     result0 = make_result(TK_STR_CHAR, 7'd12, ERR_NONE);
                  "n":     result0 = make_result(TK_STR_CHAR, 7'd10, ERR_NONE);
                  "r":     result0 = make_result(TK_STR_CHAR, 7'd13, ERR_NONE);
                  "t":     result0 = make_result(TK_STR_CHAR, 7'd9, ERR_NONE);
                  "u": begin
                     result_count        = 2'd0;
                     nxt_state.hex_count = 3'd0;
                     nxt_state.hex_accum = 16'd0;
                     nxt_state.mode      = MODE_HEX;
                  end
                  default: begin
                     result_count = 2'd0;
                     fail         = 1'b1;
                     fail_code    = ERR_BAD_ESCAPE;
                  end
               endcase
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_HEX;
               end else begin
                  nxt_state.hex_accum = hex_accum_new;
                  nxt_state.hex_count = hex_count_new;
                  if (hex_count_new >= HEX_DIGITS) begin
                     if (hex_accum_new > 16'(ASCII_MAX)) begin
                        fail      = 1'b1;
                        fail_code = ERR_HEX_RANGE;
                     end else begin
                        nxt_state.mode = MODE_STRING;
                        result_count   = 2'd1;
                        result0 = make_result(TK_STR_CHAR, hex_accum_new[6:0], ERR_NONE);
                     end
                  end
               end
            end
            MODE_NUMBER: begin
               if (in_byte == "e" || in_byte == "E" || in_byte == ".") begin
                  nxt_state.number_is_double = 1'b1;
                  result_count = 2'd1;
                  result0      = make_result(TK_NUM_CHAR, in_byte[6:0], ERR_NONE);
               end else if (in_byte == "-" || in_byte == "+" ||
                            (in_byte >= "0" && in_byte <= "9")) begin
                  result_count = 2'd1;
                  result0      = make_result(TK_NUM_CHAR, in_byte[6:0], ERR_NONE);
               end else begin
                  nxt_state    = idle_out.st;
                  result0      = make_result(num_end_kind, 7'd0, ERR_NONE);
                  result1      = idle_out.res;
                  result_count = idle_out.emit ? 2'd2 : 2'd1;
               end
            end
            MODE_KEYWORD: begin
               if (cur_state.keyword_id == 2'd3 ||
                   cur_state.keyword_pos >= kw_len(cur_state.keyword_id) ||
                   in_byte != kw_char(cur_state.keyword_id, cur_state.keyword_pos)) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_KEYWORD;
               end else begin
                  nxt_state.keyword_pos = kw_pos_new;
                  if (kw_pos_new >= kw_len(cur_state.keyword_id)) begin
                     nxt_state.mode = MODE_IDLE;
                     result_count   = 2'd1;
                     result0 = make_result(TK_TRUE + 5'(cur_state.keyword_id),
                                           7'd0, ERR_NONE);
                  end
               end
            end
            default: begin
               result_count = 2'd1;
               result0      = make_result(TK_EOF, 7'd0, ERR_NONE);
            end
         endcase
      end
      if (fail) begin
         nxt_state.halted   = 1'b1;
         nxt_state.err_code = fail_code;
         nxt_state.mode     = MODE_IDLE;
         result_count       = 2'd1;
         result0            = make_result(TK_ERROR, 7'd0, fail_code);
      end
      if (result_count == 2'd2) begin
         result1.last_of_run = 1'b1;
      end else begin
         result0.last_of_run = 1'b1;
      end
   end

endmodule

/* hw/rtl/json_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// byte-serial json lexer: whitespace skipping, structural tokens, strings with
// escapes, numbers and keywords, sticky errors
// datapath: the req byte is registered, then its lexer results are registered for rsp
// throughput: one byte per cycle while rsp is ready; a byte that gives two results
// holds the next byte back until the single rsp port drains the result register
// reset: synchronous; clears lexer state, sticky error and pending results
// ----------------------------------------------------------------------------
module json_byte_tokenizer import jbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // token_kind, char_value, error_code
   output logic        rsp_tlast    // last_of_run
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_end_ff;
   lex_state_type state_ff, state_in;
   logic [1:0]    count_ff, count_in;
   result_type    out0_ff, out0_in;
   result_type    out1_ff, out1_in;
   result_type    res0, res1;
   logic [1:0]    res_count;
   logic          pop, fire, req_take;

   jbt_lexer u_lexer (
      .cur_state    (state_ff),
      .in_byte      (in_byte_ff),
      .end_of_input (in_end_ff),
      .nxt_state    (state_in),
      .result_count (res_count),
      .result0      (res0),
      .result1      (res1)
   );

   assign pop        = rsp_tvalid && rsp_tready;
   assign fire       = in_valid_ff && (count_ff == 2'd0 || (count_ff == 2'd1 && pop));
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {out0_ff.error_code, out0_ff.char_value, out0_ff.token_kind};
   assign rsp_tlast  = out0_ff.last_of_run;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !fire);
      count_in    = count_ff;
      out0_in     = out0_ff;
      out1_in     = out1_ff;
      if (fire) begin
         count_in = res_count;
         out0_in  = res0;
         out1_in  = res1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         out0_in  = out1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         count_ff                    <= 2'd0;
         state_ff.mode               <= MODE_IDLE;
         state_ff.hex_count          <= 3'd0;
         state_ff.hex_accum          <= 16'd0;
         state_ff.keyword_id         <= 2'd0;
         state_ff.keyword_pos        <= 3'd0;
         state_ff.number_is_double   <= 1'b0;
         state_ff.halted             <= 1'b0;
         state_ff.err_code           <= ERR_NONE;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tuser;
      end
      out0_ff <= out0_in;
      out1_ff <= out1_in;
   end

endmodule

/* dv/json_byte_tokenizer_test.sv */
// ----------------------------------------------------------------------------
// json_byte_tokenizer_test
// streams json text into the tokenizer with random gaps and stalls; an
// internal lexer computes the expected tokens per accepted byte, and every
// rsp transaction is compared field by field; the run ends with one error
// or end-of-input case followed by bytes that must repeat the sticky answer
// ----------------------------------------------------------------------------
module json_byte_tokenizer_test;
   import jbt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
   } lex_input_type;

   typedef enum int {
      END_UNKNOWN_BYTE,
      END_BSLASH_EOF,
      END_BAD_ESCAPE,
      END_BAD_HEX,
      END_EOF_IN_HEX,
      END_HEX_RANGE,
      END_NON_ASCII,
      END_BAD_KEYWORD,
      END_EOF_IN_KW,
      END_OPEN_STRING,
      END_EOF_IDLE,
      END_EOF_INT,
      END_EOF_DBL
   } ending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // in_byte
   logic        req_tuser = 1'b0;   // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // token_kind, char_value, error_code
   logic        rsp_tlast;          // last_of_run

   json_byte_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   lex_input_type pending_bytes[$];
   result_type    expected_tokens[$];
   result_type    step_tokens[$];
   int            items_queued = 0;
   int            tokens_seen = 0;
   int            mismatch_count = 0;

   // lexer state
   lex_mode_type lex_mode = MODE_IDLE;
   logic [2:0]   hex_cnt = 3'd0;
   logic [15:0]  hex_val = 16'd0;
   logic [1:0]   kw_id = 2'd0;
   logic [2:0]   kw_pos = 3'd0;
   logic         num_dbl = 1'b0;
   logic         halted = 1'b0;
   logic [3:0]   held_err = ERR_NONE;

   string kw_word [0:2] = '{"true", "false", "null"};

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 120);
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void put_token(logic [4:0] kind, logic [6:0] ch, logic [3:0] err);
      result_type r;
      r.token_kind  = kind;
      r.char_value  = ch;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      if (step_tokens.size() < 2) step_tokens.push_back(r);
   endfunction

   function automatic void raise_error(logic [3:0] code);
      halted   = 1'b1;
      held_err = code;
      lex_mode = MODE_IDLE;
      put_token(TK_ERROR, 7'd0, code);
   endfunction

   function automatic int decode_hex(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return -1;
   endfunction

   function automatic void lex_idle(logic [7:0] b);
      case (b)
         "{": put_token(TK_OBJ_BEGIN, 7'd0, ERR_NONE);
         "}": put_token(TK_OBJ_END, 7'd0, ERR_NONE);
         "[": put_token(TK_ARR_BEGIN, 7'd0, ERR_NONE);
         "]": put_token(TK_ARR_END, 7'd0, ERR_NONE);
         ",": put_token(TK_COMMA, 7'd0, ERR_NONE);
         ":": put_token(TK_COLON, 7'd0, ERR_NONE);
         "\"": begin
            lex_mode = MODE_STRING;
            put_token(TK_STR_BEGIN, 7'd0, ERR_NONE);
         end
         "t", "f", "n": begin
            kw_id    = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
            kw_pos   = 3'd1;
            lex_mode = MODE_KEYWORD;
         end
         " ", "\t", "\r", "\n": ;
         default: begin
            if (b == "-" || (b >= "0" && b <= "9")) begin
               num_dbl  = 1'b0;
               lex_mode = MODE_NUMBER;
               put_token(TK_NUM_CHAR, b[6:0], ERR_NONE);
            end else begin
               raise_error(ERR_UNKNOWN_BYTE);
            end
         end
      endcase
   endfunction

   function automatic void lex_byte(logic [7:0] b);
      logic [7:0] c;
      int         h;
      string      word;
      case (lex_mode)
         MODE_IDLE: lex_idle(b);
         MODE_STRING: begin
            if (b == "\"") begin
               lex_mode = MODE_IDLE;
               put_token(TK_STR_END, 7'd0, ERR_NONE);
            end else if (b == "\\") begin
               lex_mode = MODE_ESCAPE;
            end else if (b > ASCII_MAX) begin
               raise_error(ERR_NON_ASCII);
            end else begin
               put_token(TK_STR_CHAR, b[6:0], ERR_NONE);
            end
         end
         MODE_ESCAPE: begin
            c = 8'd0;
            case (b)
               "\"", "\\", "/": c = b;
               "b": c = 8'd8;
               "f": c = 8'd12;
               "n": c = 8'd10;
               "r": c = 8'd13;
               "t": c = 8'd9;
               "u": begin
                  hex_cnt  = 3'd0;
                  hex_val  = 16'd0;
                  lex_mode = MODE_HEX;
               end
               default: raise_error(ERR_BAD_ESCAPE);
            endcase
            if (c != 8'd0) begin
               lex_mode = MODE_STRING;
               put_token(TK_STR_CHAR, c[6:0], ERR_NONE);
            end
         end
         MODE_HEX: begin
            h = decode_hex(b);
            if (h < 0) begin
               raise_error(ERR_BAD_HEX);
            end else begin
               hex_val = {hex_val[11:0], 4'(h)};
               hex_cnt = hex_cnt + 3'd1;
               if (hex_cnt >= HEX_DIGITS) begin
                  if (hex_val > 16'(ASCII_MAX)) begin
                     raise_error(ERR_HEX_RANGE);
                  end else begin
                     lex_mode = MODE_STRING;
                     put_token(TK_STR_CHAR, hex_val[6:0], ERR_NONE);
                  end
               end
            end
         end
         MODE_NUMBER: begin
            if (b == "e" || b == "E" || b == ".") begin
               num_dbl = 1'b1;
               put_token(TK_NUM_CHAR, b[6:0], ERR_NONE);
            end else if (b == "-" || b == "+" || (b >= "0" && b <= "9")) begin
               put_token(TK_NUM_CHAR, b[6:0], ERR_NONE);
            end else begin
               lex_mode = MODE_IDLE;
               put_token(num_dbl ? TK_NUM_DBL : TK_NUM_INT, 7'd0, ERR_NONE);
               lex_idle(b);
            end
         end
         MODE_KEYWORD: begin
            if (kw_id > 2'd2) begin
               raise_error(ERR_BAD_KEYWORD);
            end else begin
               word = kw_word[kw_id];
               if (kw_pos >= word.len() || b != word[kw_pos]) begin
                  raise_error(ERR_BAD_KEYWORD);
               end else begin
                  kw_pos = kw_pos + 3'd1;
                  if (kw_pos >= word.len()) begin
                     lex_mode = MODE_IDLE;
                     put_token(TK_TRUE + 5'(kw_id), 7'd0, ERR_NONE);
                  end
               end
            end
         end
         default: put_token(TK_EOF, 7'd0, ERR_NONE);
      endcase
   endfunction

   function automatic void lex_end();
      case (lex_mode)
         MODE_STRING:  raise_error(ERR_OPEN_STRING);
         MODE_ESCAPE:  raise_error(ERR_BSLASH_EOF);
         MODE_HEX:     raise_error(ERR_EOF_IN_HEX);
         MODE_KEYWORD: raise_error(ERR_EOF_IN_KW);
         default: begin
            if (lex_mode == MODE_NUMBER)
               put_token(num_dbl ? TK_NUM_DBL : TK_NUM_INT, 7'd0, ERR_NONE);
            lex_mode = MODE_DONE;
            put_token(TK_EOF, 7'd0, ERR_NONE);
         end
      endcase
   endfunction

   function automatic void predict_tokens(logic [7:0] b, logic eoi);
      step_tokens.delete();
      if (halted)
         put_token(TK_ERROR, 7'd0, held_err);
      else if (lex_mode == MODE_DONE)
         put_token(TK_EOF, 7'd0, ERR_NONE);
      else if (eoi)
         lex_end();
      else
         lex_byte(b);
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // req side
   int            send_gap = 0;
   int            req_calm = 0;
   lex_input_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_tokens(req_tdata, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_item  = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.data;
               req_tuser  <= next_item.eoi;
               send_gap   = pick_gap(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp side
   int         stall_left = 0;
   int         rsp_calm = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   result_type got_token;
   result_type want_token;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_token.token_kind  = rsp_tdata[4:0];
            got_token.char_value  = rsp_tdata[11:5];
            got_token.error_code  = rsp_tdata[15:12];
            got_token.last_of_run = rsp_tlast;
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected token at %0t: kind %0d char %0d err %0d last %0b",
                           $realtime, got_token.token_kind, got_token.char_value,
                           got_token.error_code, got_token.last_of_run);
            end else begin
               want_token = expected_tokens.pop_front();
               if (got_token.token_kind !== want_token.token_kind ||
                   got_token.char_value !== want_token.char_value ||
                   got_token.error_code !== want_token.error_code ||
                   got_token.last_of_run !== want_token.last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("token mismatch at %0t: expected kind %0d char %0d err %0d last %0b",
                              $realtime, want_token.token_kind, want_token.char_value,
                              want_token.error_code, want_token.last_of_run);
                     $display("   got kind %0d char %0d err %0d last %0b",
                              got_token.token_kind, got_token.char_value,
                              got_token.error_code, got_token.last_of_run);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && tokens_seen >= 300) begin
            // long back-pressure so the tokenizer fills up and stalls req
            hold_done = 1'b1;
            hold_left = 250;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(rsp_calm);
         end
      end
   end

   // stimulus
   task automatic send_byte(logic [7:0] b);
      lex_input_type it;
      it.data = b;
      it.eoi  = 1'b0;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   task automatic send_end();
      lex_input_type it;
      it.data = 8'($urandom_range(0, 255));
      it.eoi  = 1'b1;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_pick(string s);
      send_byte(s[$urandom_range(0, s.len() - 1)]);
   endtask

   task automatic send_hex_digit(logic [3:0] v);
      if (v < 4'd10)
         send_byte("0" + 8'(v));
      else
         send_byte(($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10);
   endtask

   task automatic send_digits(int lo, int hi);
      repeat ($urandom_range(lo, hi)) send_pick("0123456789");
   endtask

   task automatic send_number();
      if ($urandom_range(0, 2) == 0) begin
         send_pick("-0123456789");
         repeat ($urandom_range(0, 5)) send_pick("0123456789+-.eE");
      end else begin
         if ($urandom_range(0, 1)) send_byte("-");
         send_digits(1, 4);
         if ($urandom_range(0, 1)) begin
            send_byte(".");
            send_digits(1, 3);
         end
         if ($urandom_range(0, 2) == 0) begin
            send_pick("eE");
            if ($urandom_range(0, 1)) send_pick("+-");
            send_digits(1, 2);
         end
      end
   endtask

   task automatic send_string_body(int max_len);
      logic [7:0]  c;
      logic [15:0] code;
      int          r;
      repeat ($urandom_range(0, max_len)) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            do c = 8'($urandom_range(32, 126)); while (c == "\"" || c == "\\");
            send_byte(c);
         end else if (r < 75) begin
            send_byte(8'($urandom_range(0, 31)));
         end else if (r < 90) begin
            send_byte("\\");
            send_pick("\"\\/bfnrt");
         end else begin
            code = 16'($urandom_range(0, 127));
            send_text("\\u");
            for (int i = 3; i >= 0; i--) send_hex_digit(code[i*4 +: 4]);
         end
      end
   endtask

   task automatic send_token();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         send_pick("{}[],:");
      end else if (r < 35) begin
         repeat ($urandom_range(1, 3)) send_pick(" \t\r\n");
      end else if (r < 65) begin
         send_byte("\"");
         send_string_body(8);
         send_byte("\"");
      end else if (r < 85) begin
         send_number();
         send_pick(" ,]}:\t\n\r[{");
      end else begin
         send_text(kw_word[$urandom_range(0, 2)]);
      end
   endtask

   task automatic send_ending();
      ending_type ending;
      logic [7:0] b;
      string      word;
      ending = ending_type'($urandom_range(0, 12));
      case (ending)
         END_UNKNOWN_BYTE: begin
            if ($urandom_range(0, 1)) send_byte(8'($urandom_range(128, 255)));
            else send_pick("#@!x?A*=");
         end
         END_BSLASH_EOF: begin
            send_text("\"\\");
            send_end();
         end
         END_BAD_ESCAPE: begin
            send_text("\"a\\");
            send_pick("xqU0a ");
         end
         END_BAD_HEX: begin
            send_text("\"\\u0");
            send_pick("gGz \"");
         end
         END_EOF_IN_HEX: begin
            send_text("\"\\u00");
            send_end();
         end
         END_HEX_RANGE: begin
            send_text("\"\\u");
            b = 8'($urandom_range(0, 255));
            send_hex_digit(b[7:4]);
            send_hex_digit(b[3:0]);
            send_hex_digit(4'($urandom_range(8, 15)));
            send_hex_digit(4'($urandom_range(0, 15)));
         end
         END_NON_ASCII: begin
            send_text("\"ab");
            send_byte(8'($urandom_range(128, 255)));
         end
         END_BAD_KEYWORD, END_EOF_IN_KW: begin
            word = kw_word[$urandom_range(0, 2)];
            send_text(word.substr(0, $urandom_range(0, word.len() - 2)));
            if (ending == END_EOF_IN_KW) send_end();
            else send_byte("Z");
         end
         END_OPEN_STRING: begin
            send_text("\"abc");
            send_end();
         end
         END_EOF_IDLE: send_end();
         END_EOF_INT: begin
            send_text("123");
            send_end();
         end
         default: begin
            send_text("-1.5");
            send_end();
         end
      endcase
      // everything after must repeat the sticky answer
      send_byte(8'hFF);
      send_byte(8'h00);
      send_end();
      repeat (13) begin
         if ($urandom_range(0, 1)) send_end();
         else send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tokens.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      send_text(" {\"\\u007F");
      send_byte(8'h00);
      send_text("\":[-2.5E+7,true]}");
      while (items_queued < 1000) send_token();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_drained();
      while (items_queued < 2000) send_token();
      send_ending();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
